// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

// Next-cycle implication that also holds during reset.
`define ASSERT_NEXT_ALWAYS(label, clk, lhs, rhs) \
   label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

// ===== rtl/skit_pkg.sv =====
package skit_pkg;

   // Table geometry. Both sizes are powers of two so that slot and
   // character addresses are plain concatenations.
   localparam int TABLE_SIZE  = 16;
   localparam int MAX_KEY_LEN = 32;

   localparam int SLOT_W  = $clog2(TABLE_SIZE);
   localparam int KIDX_W  = $clog2(MAX_KEY_LEN);
   localparam int LEN_W   = $clog2(MAX_KEY_LEN + 1);
   localparam int CNT_W   = $clog2(TABLE_SIZE);
   localparam int PADDR_W = KIDX_W + 1;
   localparam int SADDR_W = SLOT_W + KIDX_W;
   localparam int CHAR_W  = 8;

   typedef enum logic [1:0] {
      ST_FOUND    = 2'd0,
      ST_INSERTED = 2'd1,
      ST_FULL     = 2'd2,
      ST_TOO_LONG = 2'd3
   } status_type;

   // One finished key, handed from the front part to the back part.
   typedef struct packed {
      logic [CHAR_W-1:0] hash;
      logic [LEN_W-1:0]  len;
      logic              overflow;
      logic              bank;
   } job_type;

endpackage

// ===== rtl/skit_ram.sv =====
module skit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/skit_front.sv =====
module skit_front import skit_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [CHAR_W-1:0]   key_char,
   input  logic                key_last,
   input  logic                queue_full,
   output logic                push,
   output job_type             job,
   output logic                pend_we,
   output logic [PADDR_W-1:0]  pend_addr,
   output logic [CHAR_W-1:0]   pend_data
);

   logic [CHAR_W-1:0] hash_ff, hash_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              ovf_ff, ovf_in;
   logic              bank_ff, bank_in;
   logic              accept;
   logic              room;

   // Both key banks are held when the queue is full, so the front waits.
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign room       = len_ff < LEN_W'(MAX_KEY_LEN);

   // Characters beyond the maximum length are dropped.
   assign pend_we   = accept && room;
   assign pend_addr = {bank_ff, len_ff[KIDX_W-1:0]};
   assign pend_data = key_char;

   // Running hash, length and overflow of the key in progress.
   always_comb begin
      hash_in = hash_ff ^ key_char;
      len_in  = room ? len_ff + 1'b1 : len_ff;
      ovf_in  = ovf_ff | !room;
      bank_in = bank_ff;
      push    = accept && key_last;
      job     = '{hash: hash_in, len: len_in, overflow: ovf_in, bank: bank_ff};
      if (push) begin
         hash_in = '0;
         len_in  = '0;
         ovf_in  = 1'b0;
         bank_in = !bank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
         len_ff  <= '0;
         ovf_ff  <= 1'b0;
         bank_ff <= 1'b0;
      end else if (accept) begin
         hash_ff <= hash_in;
         len_ff  <= len_in;
         ovf_ff  <= ovf_in;
         bank_ff <= bank_in;
      end
   end

endmodule

// ===== rtl/skit_queue.sv =====
module skit_queue import skit_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output job_type head
);

   job_type entry_ff [2];
   logic    wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full  = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign head  = entry_ff[rd_ptr_ff];

   // Two-entry queue, one entry for each key bank.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ===== rtl/skit_back.sv =====
module skit_back import skit_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_empty,
   input  job_type            job,
   output logic               pop,
   output logic [PADDR_W-1:0] pend_addr,
   input  logic [CHAR_W-1:0]  pend_rdata,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [SLOT_W-1:0]  rsp_id,
   output status_type         rsp_status
);

   typedef enum logic [2:0] {
      S_IDLE, S_PROBE, S_CMP_RD, S_CMP_CHK, S_CPY_RD, S_CPY_WR, S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [KIDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SLOT_W-1:0] res_id_ff, res_id_in;
   status_type        res_st_ff, res_st_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_id_ff, rsp_id_in;
   status_type        rsp_st_ff, rsp_st_in;
   logic [TABLE_SIZE-1:0] used_ff, used_in;
   logic [LEN_W-1:0]  slot_len_ff [TABLE_SIZE];
   logic              len_we;
   logic              out_free;
   logic              idx_end;
   logic [SLOT_W-1:0] slot_wrap;
   logic              chars_we;
   logic [SADDR_W-1:0] chars_addr;
   logic [CHAR_W-1:0] chars_rdata;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign idx_end   = ({1'b0, idx_ff} + 1'b1) == job.len;
   assign slot_wrap = (slot_ff == SLOT_W'(TABLE_SIZE - 1)) ? '0 : slot_ff + 1'b1;

   // Key bank and slot store are addressed by the same character index.
   assign pend_addr  = {job.bank, idx_ff};
   assign chars_addr = {slot_ff, idx_ff};
   assign chars_we   = state_ff == S_CPY_WR;

   skit_ram #(.WIDTH(CHAR_W), .DEPTH(TABLE_SIZE * MAX_KEY_LEN)) u_chars (
      .clock   (clock),
      .wr_en   (chars_we),
      .wr_addr (chars_addr),
      .wr_data (pend_rdata),
      .rd_addr (chars_addr),
      .rd_data (chars_rdata)
   );

   // Probe sequencer: read each character, then compare or copy it.
   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      res_id_in = res_id_ff;
      res_st_in = res_st_ff;
      used_in   = used_ff;
      len_we    = 1'b0;
      pop       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_id_in    = rsp_id_ff;
      rsp_st_in    = rsp_st_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               if (job.overflow) begin
                  res_id_in = '0;
                  res_st_in = ST_TOO_LONG;
                  state_in  = S_DONE;
               end else begin
                  slot_in  = job.hash[SLOT_W-1:0];
                  cnt_in   = '0;
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            idx_in = '0;
            if (!used_ff[slot_ff]) begin
               state_in = S_CPY_RD;
            end else if (slot_len_ff[slot_ff] == job.len) begin
               state_in = S_CMP_RD;
            end else if (cnt_ff == CNT_W'(TABLE_SIZE - 1)) begin
               res_id_in = '0;
               res_st_in = ST_FULL;
               state_in  = S_DONE;
            end else begin
               slot_in  = slot_wrap;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_PROBE;
            end
         end
         S_CMP_RD: begin
            state_in = S_CMP_CHK;
         end
         S_CMP_CHK: begin
            if (chars_rdata != pend_rdata) begin
               if (cnt_ff == CNT_W'(TABLE_SIZE - 1)) begin
                  res_id_in = '0;
                  res_st_in = ST_FULL;
                  state_in  = S_DONE;
               end else begin
                  slot_in  = slot_wrap;
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = S_PROBE;
               end
            end else if (idx_end) begin
               res_id_in = slot_ff;
               res_st_in = ST_FOUND;
               state_in  = S_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_CMP_RD;
            end
         end
         S_CPY_RD: begin
            state_in = S_CPY_WR;
         end
         S_CPY_WR: begin
            if (idx_end) begin
               used_in[slot_ff] = 1'b1;
               len_we    = 1'b1;
               res_id_in = slot_ff;
               res_st_in = ST_INSERTED;
               state_in  = S_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_CPY_RD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = res_id_ff;
               rsp_st_in    = res_st_ff;
               pop          = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      idx_ff    <= idx_in;
      cnt_ff    <= cnt_in;
      res_id_ff <= res_id_in;
      res_st_ff <= res_st_in;
      rsp_id_ff <= rsp_id_in;
      rsp_st_ff <= rsp_st_in;
      if (len_we) begin
         slot_len_ff[slot_ff] <= job.len;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_id     = rsp_id_ff;
   assign rsp_status = rsp_st_ff;

endmodule

// ===== rtl/string_key_intern_table_top.sv =====
// String key interning table.
// Input channel req_*: one key character per item in req_tdata, req_tlast
// set on the final character. Result channel rsp_*: one item per key,
// slot id in bits 3:0 and status in bits 5:4 (found, inserted, table full,
// key too long). Characters are taken one per cycle, while the queue is not
// full, into one of two key banks while the back part probes the previous key.
// After the last character the probe starts at the slot given by the hash,
// steps through the slots in turn, compares each character on a slot of equal
// length in a read state and a check state, and copies each character on
// insertion in a read state and a write state; the registered reads of the
// key bank and slot character memories set this.
// Reset empties the table at once; no clearing pass is needed.
// When the receiver stalls, the result is held in the output register, the
// next result waits in the back part until it is taken, and input stops once
// both key banks hold finished keys.
module string_key_intern_table_top import skit_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // key_char [7:0]
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // key_id [3:0], lookup_status [5:4], zero [7:6]
);

   logic               push, pop, q_full, q_empty;
   job_type            push_job, head_job;
   logic               pend_we;
   logic [PADDR_W-1:0] pend_waddr, pend_raddr;
   logic [CHAR_W-1:0]  pend_wdata, pend_rdata;
   logic [SLOT_W-1:0]  rsp_id;
   status_type         rsp_status;

   skit_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .key_char   (req_tdata),
      .key_last   (req_tlast),
      .queue_full (q_full),
      .push       (push),
      .job        (push_job),
      .pend_we    (pend_we),
      .pend_addr  (pend_waddr),
      .pend_data  (pend_wdata)
   );

   // Two key banks of pending characters.
   skit_ram #(.WIDTH(CHAR_W), .DEPTH(2 * MAX_KEY_LEN)) u_pending (
      .clock   (clock),
      .wr_en   (pend_we),
      .wr_addr (pend_waddr),
      .wr_data (pend_wdata),
      .rd_addr (pend_raddr),
      .rd_data (pend_rdata)
   );

   skit_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (head_job)
   );

   skit_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (q_empty),
      .job         (head_job),
      .pop         (pop),
      .pend_addr   (pend_raddr),
      .pend_rdata  (pend_rdata),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_id      (rsp_id),
      .rsp_status  (rsp_status)
   );

   assign rsp_tdata = {2'b00, rsp_status, rsp_id};

endmodule

// ===== rtl/skit_checker.sv =====
`include "assert_macros.svh"

module skit_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // Error results carry slot id zero.
   `ASSERT_IMPLY(a_err_id_zero, clock, reset, rsp_tvalid && rsp_tdata[5], rsp_tdata[3:0] == 4'd0)

   // Padding bits of a result are always zero.
   `ASSERT_IMPLY(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[7:6] == 2'b00)

   // No result is shown in the cycle after reset.
   `ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_tvalid)

   // The input is open in the cycle after reset, since the queue is empty.
   `ASSERT_NEXT_ALWAYS(a_reset_ready, clock, reset, req_tready)

   // A stalled result holds.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind string_key_intern_table_top skit_checker u_skit_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
